// ===== hdl/bitmap_contiguous_page_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap page allocator
// Clocked on clk and disabled while rst_n is low. The checks compile away
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BCPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BCPA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BCPA_ASSERT(name, prop, msg)
`define BCPA_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

// ===== hdl/bcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Command codes, configuration register indexes and bit-scan helpers.
// ----------------------------------------------------------------------------
package bcpa_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_FREE      = 2'd1,
    CMD_TRANSLATE = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_e_t;

  localparam logic CFG_VIRT_BASE = 1'b0;
  localparam logic CFG_PHYS_BASE = 1'b1;

  // Number of zero bits below the lowest set bit; 32 for an all-zero word.
  function automatic logic [5:0] ctz32(input logic [31:0] v);
    logic [5:0] r;
    r = 6'd32;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  // Number of zero bits above the highest set bit; 32 for an all-zero word.
  function automatic logic [5:0] clz32(input logic [31:0] v);
    logic [5:0] r;
    r = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        r = 6'(31 - i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/bitmap_contiguous_page_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap contiguous page allocator
// First-fit allocator over a region of NUM_PAGES pages with one occupancy
// bit per page, plus free and virtual-to-physical page translation.
// ----------------------------------------------------------------------------
// The occupancy map lives in a memory of 32-bit words with one write and one
// registered read each cycle; allocate and free are read-modify-write walks
// over it. After reset a clearing pass zeroes every map word before the first
// input beat is taken. Translate and undefined commands go from dispatch to the
// response state. Allocate scans map words up to the one where the run ends,
// then updates every word the run covers; a failed allocate scans all words.
// Free updates every map word it touches, or goes straight to the response
// when the pages lie outside the region. One command is in flight at a time; a
// finished result waits in the output register while the next input beat is
// taken.
`include "bitmap_contiguous_page_allocator_defines.svh"

module bitmap_contiguous_page_allocator
  import bcpa_pkg::*;
#(
  parameter int NUM_PAGES  = 1024,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [23:0] in_request_bytes,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_address,
  output logic        out_ok,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int MAP_WORDS = (NUM_PAGES + 31) / 32;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PGX_W     = WA_W + 5;
  localparam int CNT_W     = 25 - PAGE_SHIFT;
  localparam int LOF_W     = 32 - PAGE_SHIFT;
  localparam logic [WA_W-1:0]  LAST_WORD   = WA_W'(MAP_WORDS - 1);
  localparam logic [PGX_W-1:0] LAST_PAGE   = PGX_W'(NUM_PAGES - 1);
  localparam logic [LOF_W:0]   LAST_PAGE_X = (LOF_W + 1)'(NUM_PAGES - 1);
  localparam logic [LOF_W:0]   NUM_PAGES_X = (LOF_W + 1)'(NUM_PAGES);
  localparam logic [31:0]      PAGE_MASK   = 32'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [31:0]      TAIL_USED   = ((NUM_PAGES % 32) == 0) ? 32'd0 :
                                             ~32'((64'd1 << (NUM_PAGES % 32)) - 64'd1);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DISP   = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_RMW_RD = 7'b0010000,
    ST_RMW_WR = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  state_t            state_r;
  logic [WA_W-1:0]   clr_r;
  cmd_e_t            cmd_r;
  logic [CNT_W-1:0]  n_r;
  logic [31:0]       diff_r;
  logic [WA_W-1:0]   sw_r;
  logic [CNT_W-1:0]  run_r;
  logic [PGX_W-1:0]  run_start_r;
  logic [PGX_W-1:0]  lo_r;
  logic [PGX_W-1:0]  hi_r;
  logic [WA_W-1:0]   cw_r;
  logic [31:0]       res_addr_r;
  logic              res_ok_r;
  logic              out_valid_r;
  logic [31:0]       out_addr_r;
  logic              out_ok_r;
  logic [31:0]       vb_r;
  logic [31:0]       pb_r;

  logic [31:0]       map_mem [MAP_WORDS];
  logic [31:0]       rdata_r;
  logic              mem_we;
  logic [WA_W-1:0]   mem_wa;
  logic [31:0]       mem_wd;
  logic [WA_W-1:0]   mem_ra;

  logic              in_beat;
  logic [24:0]       bytes_sum;
  logic [CNT_W-1:0]  n_in;

  logic [31:0]       scan_m;
  logic [5:0]        tz;
  logic [5:0]        lz;
  logic [CNT_W-1:0]  need;
  logic              carry_hit;
  logic              small_n;
  logic [5:0]        n6;
  logic [2:0]        msb_j;
  logic [31:0]       aw [6];
  logic [31:0]       wsel;
  logic [5:0]        wshift;
  logic [31:0]       win;
  logic [5:0]        win_tz;
  logic              win_hit;
  logic              scan_hit;
  logic [PGX_W-1:0]  word_base;
  logic [PGX_W-1:0]  hit_start;
  logic [CNT_W-1:0]  run_nxt;
  logic [PGX_W-1:0]  run_start_nxt;

  logic [LOF_W-1:0]  lo_full;
  logic [LOF_W:0]    last_full;
  logic              free_in_region;
  logic [LOF_W:0]    free_hi;

  logic [WA_W-1:0]   lo_word;
  logic [WA_W-1:0]   hi_word;
  logic [4:0]        lo_off;
  logic [4:0]        hi_off;
  logic [31:0]       rmw_mask;
  logic              rmw_last;

  assign in_ready           = (state_r == ST_IDLE);
  assign in_beat            = in_valid && in_ready;
  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_ok             = out_ok_r;

  // Page count of a byte size, at least one page.
  always_comb begin
    bytes_sum = {1'b0, in_request_bytes} + 25'(PAGE_MASK);
    n_in      = bytes_sum[24:PAGE_SHIFT];
    if (n_in == '0) begin
      n_in = CNT_W'(1);
    end
  end

  // Scan of one map word. A run either continues the free run carried in from
  // lower words, or for short requests lies wholly inside this word.
  always_comb begin
    scan_m    = rdata_r | ((sw_r == LAST_WORD) ? TAIL_USED : 32'd0);
    tz        = ctz32(scan_m);
    lz        = clz32(scan_m);
    need      = n_r - run_r;
    carry_hit = (need <= CNT_W'(tz));
    small_n   = (n_r <= CNT_W'(32));
    n6        = n_r[5:0];
    msb_j     = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (n6[i]) begin
        msb_j = 3'(i);
      end
    end
    aw[0] = ~scan_m;
    for (int k = 1; k < 6; k++) begin
      aw[k] = aw[k-1] & (aw[k-1] >> (1 << (k - 1)));
    end
    wsel      = aw[msb_j];
    wshift    = n6 - (6'd1 << msb_j);
    win       = wsel & (wsel >> wshift);
    win_tz    = ctz32(win);
    win_hit   = small_n && (win != 32'd0);
    scan_hit  = carry_hit || win_hit;
    word_base = {sw_r, 5'd0};
    if (carry_hit) begin
      hit_start = (run_r == '0) ? word_base : run_start_r;
    end else begin
      hit_start = word_base + PGX_W'(win_tz);
    end
    if (scan_m == 32'd0) begin
      run_nxt       = run_r + CNT_W'(32);
      run_start_nxt = (run_r == '0) ? word_base : run_start_r;
    end else begin
      run_nxt       = CNT_W'(lz);
      run_start_nxt = word_base + PGX_W'(6'd32 - lz);
    end
  end

  // Page range of a free, clipped to the region.
  always_comb begin
    lo_full        = diff_r[31:PAGE_SHIFT];
    last_full      = {1'b0, lo_full} + (LOF_W + 1)'(n_r) - (LOF_W + 1)'(1);
    free_in_region = ({1'b0, lo_full} < NUM_PAGES_X);
    free_hi        = (last_full > LAST_PAGE_X) ? LAST_PAGE_X : last_full;
  end

  always_comb begin
    lo_word  = lo_r[PGX_W-1:5];
    hi_word  = hi_r[PGX_W-1:5];
    lo_off   = (cw_r == lo_word) ? lo_r[4:0] : 5'd0;
    hi_off   = (cw_r == hi_word) ? hi_r[4:0] : 5'd31;
    rmw_mask = ({32{1'b1}} << lo_off) & ({32{1'b1}} >> (5'd31 - hi_off));
    rmw_last = (cw_r == hi_word);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cw_r;
    mem_wd = (cmd_r == CMD_ALLOC) ? (rdata_r | rmw_mask) : (rdata_r & ~rmw_mask);
    mem_ra = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = 32'd0;
      end
      ST_SCAN: begin
        mem_ra = (sw_r == LAST_WORD) ? '0 : sw_r + WA_W'(1);
      end
      ST_RMW_RD: begin
        mem_ra = lo_word;
      end
      ST_RMW_WR: begin
        mem_we = 1'b1;
        mem_ra = rmw_last ? cw_r : cw_r + WA_W'(1);
      end
      default: begin
        mem_ra = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rdata_r <= map_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 32'd0;
      pb_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VIRT_BASE: vb_r <= cfg_wdata;
        CFG_PHYS_BASE: pb_r <= cfg_wdata;
        default: begin
          vb_r <= vb_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_RESP)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + WA_W'(1);
          if (clr_r == LAST_WORD) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_beat) begin
            cmd_r   <= cmd_e_t'(in_cmd);
            n_r     <= n_in;
            diff_r  <= in_address - vb_r;
            state_r <= ST_DISP;
          end
        end
        ST_DISP: begin
          res_addr_r <= 32'd0;
          res_ok_r   <= 1'b0;
          case (cmd_r)
            CMD_ALLOC: begin
              sw_r        <= '0;
              run_r       <= '0;
              run_start_r <= '0;
              state_r     <= ST_SCAN;
            end
            CMD_FREE: begin
              res_ok_r <= 1'b1;
              lo_r     <= PGX_W'(lo_full);
              hi_r     <= PGX_W'(free_hi);
              state_r  <= free_in_region ? ST_RMW_RD : ST_RESP;
            end
            CMD_TRANSLATE: begin
              res_addr_r <= pb_r + (diff_r & ~PAGE_MASK);
              res_ok_r   <= 1'b1;
              state_r    <= ST_RESP;
            end
            default: begin
              state_r <= ST_RESP;
            end
          endcase
        end
        ST_SCAN: begin
          if (scan_hit) begin
            lo_r    <= hit_start;
            state_r <= ST_RMW_RD;
          end else if (sw_r == LAST_WORD) begin
            state_r <= ST_RESP;
          end else begin
            sw_r        <= sw_r + WA_W'(1);
            run_r       <= run_nxt;
            run_start_r <= run_start_nxt;
          end
        end
        ST_RMW_RD: begin
          cw_r <= lo_word;
          if (cmd_r == CMD_ALLOC) begin
            hi_r       <= lo_r + PGX_W'(n_r - CNT_W'(1));
            res_addr_r <= vb_r + (32'(lo_r) << PAGE_SHIFT);
            res_ok_r   <= 1'b1;
          end
          state_r <= ST_RMW_WR;
        end
        ST_RMW_WR: begin
          if (rmw_last) begin
            state_r <= ST_RESP;
          end else begin
            cw_r <= cw_r + WA_W'(1);
          end
        end
        ST_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_addr_r  <= res_addr_r;
            out_ok_r    <= res_ok_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `BCPA_ASSERT(a_scan_run_short, (state_r == ST_SCAN) |-> (run_r < n_r), "carried free run reached the request without a hit")
  `BCPA_ASSERT(a_rmw_in_range, (state_r == ST_RMW_WR) |-> ((cw_r <= hi_word) && (lo_r <= hi_r) && (hi_r <= LAST_PAGE)), "map update outside its page range")
  `BCPA_ASSERT_NEXT(a_resp_holds, (state_r == ST_RESP) && out_valid_r && !out_ready, state_r == ST_RESP, "result dropped while the output beat was stalled")

endmodule
